>>> src/bad_pkg.sv
package bad_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
  localparam int OFF_BAND_SCORE = -1000000;
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 12;
  localparam int DIST_W = 17;
  localparam int FRAC_BITS = 16;

  localparam logic [2:0] MOVE_NONE = 3'b000;
  localparam logic [2:0] MOVE_DIAG = 3'b001;
  localparam logic [2:0] MOVE_VER  = 3'b010;
  localparam logic [2:0] MOVE_HOR  = 3'b100;

  typedef enum logic [CFG_IW-1:0] {
    REG_MATCH,
    REG_MISMATCH,
    REG_GAP_OPEN,
    REG_GAP_EXTEND,
    REG_THRESHOLD,
    REG_TOLERANCE,
    REG_BAND_DIVISOR
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] match_score;
    logic signed [7:0] mismatch_score;
    logic signed [7:0] gap_open;
    logic signed [7:0] gap_extend;
    logic [16:0]       threshold;
    logic [7:0]        tolerance;
    logic [7:0]        band_divisor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    match_score:    8'sd1,
    mismatch_score: -8'sd1,
    gap_open:       -8'sd2,
    gap_extend:     -8'sd1,
    threshold:      17'd6554,
    tolerance:      8'd1,
    band_divisor:   8'd0
  };

  typedef enum logic [2:0] {
    C_IDLE,
    C_KDIV,
    C_ROW,
    C_READ,
    C_CALC,
    C_FIN,
    C_QDIV,
    C_OUT
  } core_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [COUNT_W-1:0] inc_count(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

>>> src/banded_alignment_distance.sv
// Banded alignment distance between two reads. Bases stream in one per cycle on
// s_axis (tuser 0 = first read, 1 = second read), up to MAX_LEN per read; tlast marks
// the last base of a pair. The pair is then scored over the alignment matrix one
// cell at a time through a single row buffer, with a read step and a calculate step
// per cell and a row set-up step per row. A band width division comes first when
// band_divisor is nonzero, and a division for the final Q1.16 ratio comes last;
// input is stalled while a pair is scored. One result item per pair leaves on
// m_axis, held in an output register, so loading of the next pair may start while it
// waits.
module banded_alignment_distance #(
  parameter int MAX_LEN = 1024,
  parameter int SCORE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // base
  input  logic                        s_axis_tuser,   // read_select
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // distance[16:0], mismatch_count[28:17], align_length[40:29], accepted[41], zeros
  output logic [47:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,   // empty_pair
  input  logic                        cfg_we,
  input  logic [bad_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bad_pkg::CFG_DW-1:0]  cfg_data
);
  import bad_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int JW = 2 * LW + 1;

  cfg_t cfg;

  logic          push;
  logic [JW-1:0] job_in;
  logic [JW-1:0] job_out;
  logic          q_empty;
  logic          q_full;
  logic          job_pop;
  logic          core_busy;
  logic [AW-1:0] rd1_addr;
  logic [AW-1:0] rd2_addr;
  logic [7:0]    rd1_data;
  logic [7:0]    rd2_data;
  logic          div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  div_status_t   div_status;
  logic [DIV_NW-1:0] div_quotient;
  logic [DIST_W-1:0]  distance;
  logic [COUNT_W-1:0] mismatch_count;
  logic [COUNT_W-1:0] align_length;
  logic               accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MATCH:        cfg.match_score    <= cfg_data[7:0];
        REG_MISMATCH:     cfg.mismatch_score <= cfg_data[7:0];
        REG_GAP_OPEN:     cfg.gap_open       <= cfg_data[7:0];
        REG_GAP_EXTEND:   cfg.gap_extend     <= cfg_data[7:0];
        REG_THRESHOLD:    cfg.threshold      <= cfg_data[16:0];
        REG_TOLERANCE:    cfg.tolerance      <= cfg_data[7:0];
        REG_BAND_DIVISOR: cfg.band_divisor   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bad_front #(.MAX_LEN(MAX_LEN), .LW(LW), .AW(AW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .read_select (s_axis_tuser),
    .base        (s_axis_tdata),
    .end_of_pair (s_axis_tlast),
    .hold        (core_busy || !q_empty || q_full),
    .push        (push),
    .job         (job_in),
    .rd1_addr    (rd1_addr),
    .rd2_addr    (rd2_addr),
    .rd1_data    (rd1_data),
    .rd2_data    (rd2_data)
  );

  bad_jobq #(.W(JW)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (q_empty),
    .full  (q_full)
  );

  bad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quotient (div_quotient)
  );

  bad_core #(.MAX_LEN(MAX_LEN), .SCORE_BITS(SCORE_BITS), .LW(LW), .AW(AW)) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .job_valid      (!q_empty),
    .job            (job_out),
    .job_pop        (job_pop),
    .busy           (core_busy),
    .rd1_addr       (rd1_addr),
    .rd2_addr       (rd2_addr),
    .rd1_data       (rd1_data),
    .rd2_data       (rd2_data),
    .div_start      (div_start),
    .div_dividend   (div_dividend),
    .div_divisor    (div_divisor),
    .div_status     (div_status),
    .div_quotient   (div_quotient),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .distance       (distance),
    .mismatch_count (mismatch_count),
    .align_length   (align_length),
    .accepted       (accepted),
    .empty_pair     (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, accepted, align_length, mismatch_count, distance};
endmodule

>>> src/bad_jobq.sv
module bad_jobq #(
  parameter int W = 23
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= din;
  end
endmodule

>>> src/bad_div.sv
module bad_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bad_pkg::DIV_NW-1:0]  dividend,
  input  logic [bad_pkg::DIV_DW-1:0]  divisor,
  output bad_pkg::div_status_t        status,
  output logic [bad_pkg::DIV_NW-1:0]  quotient
);
  import bad_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_NW-1:0] quo;
  logic [CW-1:0]     count;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign status   = '{busy: busy, done: done};
  assign quotient = quo;
  assign rem_sh   = {rem, quo[DIV_NW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(DIV_NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DIV_DW'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], ge};
    end
  end
endmodule

>>> src/bad_front.sv
module bad_front #(
  parameter int MAX_LEN = 1024,
  parameter int LW = 11,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            read_select,
  input  logic [7:0]      base,
  input  logic            end_of_pair,
  input  logic            hold,
  output logic            push,
  output logic [2*LW:0]   job,
  input  logic [AW-1:0]   rd1_addr,
  input  logic [AW-1:0]   rd2_addr,
  output logic [7:0]      rd1_data,
  output logic [7:0]      rd2_data
);
  import bad_pkg::*;

  logic [7:0]    first_read  [MAX_LEN];
  logic [7:0]    second_read [MAX_LEN];
  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic [LW-1:0] first_length_next;
  logic [LW-1:0] second_length_next;
  logic          accept;
  logic          store1;
  logic          store2;

  assign in_ready = !hold;
  assign accept   = in_valid && in_ready;
  assign store1   = accept && !read_select && (first_length < LW'(MAX_LEN));
  assign store2   = accept && read_select && (second_length < LW'(MAX_LEN));

  assign first_length_next  = first_length + LW'(store1);
  assign second_length_next = second_length + LW'(store2);

  assign push = accept && end_of_pair;
  assign job  = {(first_length_next == '0) || (second_length_next == '0),
                 second_length_next, first_length_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
    end else if (push) begin
      first_length  <= '0;
      second_length <= '0;
    end else begin
      first_length  <= first_length_next;
      second_length <= second_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store1) first_read[first_length[AW-1:0]] <= base;
    if (store2) second_read[second_length[AW-1:0]] <= base;
    rd1_data <= first_read[rd1_addr];
    rd2_data <= second_read[rd2_addr];
  end

  a_len1_bound: assert property (@(posedge clk) disable iff (rst)
    first_length <= LW'(MAX_LEN)) else $error("first read length overflow");
  a_len2_bound: assert property (@(posedge clk) disable iff (rst)
    second_length <= LW'(MAX_LEN)) else $error("second read length overflow");
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    push |=> (first_length == '0) && (second_length == '0))
    else $error("lengths not cleared after end of pair");
endmodule

>>> src/bad_core.sv
module bad_core #(
  parameter int MAX_LEN = 1024,
  parameter int SCORE_BITS = 24,
  parameter int LW = 11,
  parameter int AW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bad_pkg::cfg_t                 cfg,
  input  logic                          job_valid,
  input  logic [2*LW:0]                 job,
  output logic                          job_pop,
  output logic                          busy,
  output logic [AW-1:0]                 rd1_addr,
  output logic [AW-1:0]                 rd2_addr,
  input  logic [7:0]                    rd1_data,
  input  logic [7:0]                    rd2_data,
  output logic                          div_start,
  output logic [bad_pkg::DIV_NW-1:0]    div_dividend,
  output logic [bad_pkg::DIV_DW-1:0]    div_divisor,
  input  bad_pkg::div_status_t          div_status,
  input  logic [bad_pkg::DIV_NW-1:0]    div_quotient,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bad_pkg::DIST_W-1:0]    distance,
  output logic [bad_pkg::COUNT_W-1:0]   mismatch_count,
  output logic [bad_pkg::COUNT_W-1:0]   align_length,
  output logic                          accepted,
  output logic                          empty_pair
);
  import bad_pkg::*;

  localparam int W  = (SCORE_BITS + 2 > 22) ? SCORE_BITS + 2 : 22;
  localparam int RW = SCORE_BITS + 3 + 2 * COUNT_W;
  localparam logic signed [W-1:0] S_HI = W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [W-1:0] S_LO = -S_HI - W'(1);
  localparam logic signed [W-1:0] S_OFF = W'(OFF_BAND_SCORE);

  function automatic logic in_band(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                   input logic [LW:0] kk, input logic fb);
    logic signed [LW+1:0] d;
    logic signed [LW+1:0] ks;
    d  = $signed({2'b00, a}) - $signed({2'b00, b});
    ks = $signed({1'b0, kk});
    return fb || ((d <= ks) && (d >= -ks));
  endfunction

  function automatic logic [COUNT_W-1:0] sat_len(input logic [31:0] v);
    return (v > 32'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_W-1:0];
  endfunction

  core_state_t state;
  core_state_t state_next;

  logic [LW-1:0] len1;
  logic [LW-1:0] len2;
  logic          full;
  logic [LW:0]   k;
  logic [LW-1:0] i;
  logic [LW-1:0] j;
  logic [LW-1:0] im1;
  logic [LW-1:0] jm1;

  logic signed [SCORE_BITS-1:0] l_score;
  logic [2:0]                   l_move;
  logic [COUNT_W-1:0]           l_mm;
  logic [COUNT_W-1:0]           l_len;
  logic signed [SCORE_BITS-1:0] d_score;
  logic [COUNT_W-1:0]           d_mm;
  logic [COUNT_W-1:0]           d_len;

  logic signed [SCORE_BITS-1:0] brow_s;
  logic [COUNT_W-1:0]           brow_mm;
  logic [COUNT_W-1:0]           brow_al;
  logic signed [SCORE_BITS-1:0] bcol_s;
  logic [COUNT_W-1:0]           bcol_mm;
  logic [COUNT_W-1:0]           bcol_al;

  logic [COUNT_W-1:0] res_mm;
  logic [COUNT_W-1:0] res_al;
  logic [DIST_W-1:0]  res_dist;
  logic               res_acc;
  logic               res_empty;

  logic [RW-1:0] row_mem [MAX_LEN];
  logic [RW-1:0] row_q;
  logic          row_we;

  logic signed [SCORE_BITS-1:0] v_score;
  logic [2:0]                   v_move;
  logic [COUNT_W-1:0]           v_mm;
  logic [COUNT_W-1:0]           v_len;
  logic                         same;
  logic                         cell_ib;
  logic                         hor_ib;
  logic                         ver_ib;
  logic signed [W-1:0]          diag_w;
  logic signed [W-1:0]          hor_w;
  logic signed [W-1:0]          ver_w;
  logic signed [W-1:0]          best_w;
  logic signed [SCORE_BITS-1:0] n_score;
  logic [2:0]                   n_move;
  logic [COUNT_W-1:0]           n_mm;
  logic [COUNT_W-1:0]           n_len;
  logic                         job_empty;
  logic                         use_row;
  logic [COUNT_W-1:0]           sel_mm;
  logic [COUNT_W-1:0]           sel_al;
  logic                         slot_free;

  assign job_empty = job[2*LW];
  assign im1       = i - 1'b1;
  assign jm1       = j - 1'b1;
  assign rd1_addr  = jm1[AW-1:0];
  assign rd2_addr  = im1[AW-1:0];
  assign busy      = (state != C_IDLE) && (state != C_OUT);
  assign use_row   = brow_s > bcol_s;
  assign sel_mm    = use_row ? brow_mm : bcol_mm;
  assign sel_al    = use_row ? brow_al : bcol_al;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    same = rd1_data == rd2_data;
    if (i == LW'(1)) begin
      v_score = '0;
      v_move  = MOVE_NONE;
      v_mm    = '0;
      v_len   = sat_len(32'(j));
    end else begin
      {v_score, v_move, v_mm, v_len} = row_q;
    end
    cell_ib = in_band(i, j, k, full);
    hor_ib  = in_band(i, jm1, k, full);
    ver_ib  = in_band(im1, j, k, full);

    diag_w = W'(d_score) + W'(same ? cfg.match_score : cfg.mismatch_score);
    hor_w  = S_OFF;
    if (hor_ib) begin
      hor_w = W'(l_score);
      if (l_move == MOVE_DIAG) hor_w = W'(l_score) + W'(cfg.gap_open);
      else if (l_move == MOVE_HOR) hor_w = W'(l_score) + W'(cfg.gap_extend);
    end
    ver_w = S_OFF;
    if (ver_ib) begin
      ver_w = W'(v_score);
      if (v_move == MOVE_DIAG) ver_w = W'(v_score) + W'(cfg.gap_open);
      else if (v_move == MOVE_VER) ver_w = W'(v_score) + W'(cfg.gap_extend);
    end

    if (diag_w >= hor_w && diag_w >= ver_w) begin
      best_w = diag_w;
      n_move = MOVE_DIAG;
      n_mm   = same ? d_mm : inc_count(d_mm);
      n_len  = inc_count(d_len);
    end else if (hor_w >= ver_w) begin
      best_w = hor_w;
      n_move = MOVE_HOR;
      n_mm   = inc_count(l_mm);
      n_len  = inc_count(l_len);
    end else begin
      best_w = ver_w;
      n_move = MOVE_VER;
      n_mm   = inc_count(v_mm);
      n_len  = inc_count(v_len);
    end
    if (best_w > S_HI) n_score = S_HI[SCORE_BITS-1:0];
    else if (best_w < S_LO) n_score = S_LO[SCORE_BITS-1:0];
    else n_score = best_w[SCORE_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (job_valid) begin
          if (job_empty) state_next = C_OUT;
          else if (cfg.band_divisor == '0) state_next = C_ROW;
          else state_next = C_KDIV;
        end
      end
      C_KDIV: if (div_status.done) state_next = C_ROW;
      C_ROW:  state_next = C_READ;
      C_READ: state_next = C_CALC;
      C_CALC: begin
        if (j != len1) state_next = C_READ;
        else if (i != len2) state_next = C_ROW;
        else state_next = C_FIN;
      end
      C_FIN:  state_next = (sel_al == '0) ? C_OUT : C_QDIV;
      C_QDIV: if (div_status.done) state_next = C_OUT;
      C_OUT:  if (slot_free) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    job_pop      = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_NW'({len1, 1'b0} + {1'b0, len2} - {1'b0, len2});
    div_divisor  = DIV_DW'({cfg.band_divisor, 1'b0});
    row_we       = 1'b0;
    case (state)
      C_IDLE: begin
        job_pop      = job_valid;
        div_start    = job_valid && !job_empty && (cfg.band_divisor != '0);
        div_dividend = DIV_NW'({1'b0, job[LW-1:0]} + {1'b0, job[2*LW-1:LW]});
      end
      C_CALC: row_we = cell_ib;
      C_FIN: begin
        div_start    = sel_al != '0;
        div_dividend = (DIV_NW'(sel_mm) << FRAC_BITS) + DIV_NW'(sel_al >> 1);
        div_divisor  = DIV_DW'(sel_al);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == C_OUT && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[jm1[AW-1:0]] <= {n_score, n_move, n_mm, n_len};
    row_q <= row_mem[jm1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        len1      <= job[LW-1:0];
        len2      <= job[2*LW-1:LW];
        full      <= cfg.band_divisor == '0;
        k         <= '0;
        i         <= LW'(1);
        brow_s    <= '0;
        brow_mm   <= '0;
        brow_al   <= '0;
        bcol_s    <= '0;
        bcol_mm   <= '0;
        bcol_al   <= '0;
        res_mm    <= '0;
        res_al    <= '0;
        res_dist  <= '0;
        res_acc   <= 1'b0;
        res_empty <= job_empty;
      end
      C_KDIV: if (div_status.done) k <= div_quotient[LW:0];
      C_ROW: begin
        j       <= LW'(1);
        l_score <= '0;
        l_move  <= MOVE_NONE;
        l_mm    <= '0;
        l_len   <= sat_len(32'(i));
        d_score <= '0;
        d_mm    <= '0;
        d_len   <= sat_len(32'(im1));
      end
      C_CALC: begin
        l_score <= n_score;
        l_move  <= n_move;
        l_mm    <= n_mm;
        l_len   <= n_len;
        d_score <= v_score;
        d_mm    <= v_mm;
        d_len   <= v_len;
        if (cell_ib && i == len2 && n_score >= brow_s) begin
          brow_s  <= n_score;
          brow_mm <= n_mm;
          brow_al <= n_len;
        end
        if (cell_ib && j == len1 && n_score >= bcol_s) begin
          bcol_s  <= n_score;
          bcol_mm <= n_mm;
          bcol_al <= n_len;
        end
        if (j != len1) j <= j + 1'b1;
        else i <= i + 1'b1;
      end
      C_FIN: begin
        res_mm <= sel_mm;
        res_al <= sel_al;
      end
      C_QDIV: begin
        if (div_status.done) begin
          res_dist <= div_quotient[DIST_W-1:0];
          res_acc  <= {1'b0, div_quotient[DIST_W-1:0]}
                      <= ({1'b0, cfg.threshold} + (DIST_W + 1)'(cfg.tolerance));
        end
      end
      C_OUT: begin
        if (slot_free) begin
          distance       <= res_dist;
          mismatch_count <= res_mm;
          align_length   <= res_al;
          accepted       <= res_acc;
          empty_pair     <= res_empty;
        end
      end
      default: ;
    endcase
  end

  a_calc_after_read: assert property (@(posedge clk) disable iff (rst)
    state == C_CALC |-> $past(state) == C_READ) else $error("cell step out of order");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    state == C_READ |-> (j != '0) && (j <= len1)) else $error("column index out of range");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy) else $error("divider started while busy");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> busy || state == C_OUT) else $error("job taken without starting");
endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import bad_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam int SCORE_BITS = 24;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_ITEMS = 112;
  localparam logic [CFG_IW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [16:0] distance;
    logic [11:0] mm;
    logic [11:0] al;
    logic        acc;
    logic        empty;
  } pair_result_t;

  typedef struct packed {
    logic         sel;
    logic [7:0]   b;
    logic         last;
    logic         typed;
    pair_result_t r;
  } stim_row_t;

  localparam pair_result_t EMPTY_R = '{17'd0, 12'd0, 12'd0, 1'b0, 1'b1};
  localparam pair_result_t IDENT_R = '{17'd0, 12'd0, 12'd1, 1'b1, 1'b0};
  localparam pair_result_t NO_R = '0;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  banded_alignment_distance dut (.*);

  // model copy of the block
  logic signed [7:0] cf_match, cf_mismatch, cf_gap_open, cf_gap_extend;
  int cf_threshold, cf_tolerance, cf_band;
  logic [7:0] read1 [MAX_LEN];
  logic [7:0] read2 [MAX_LEN];
  longint row_score [2][MAX_LEN+1];
  logic [2:0] row_move [2][MAX_LEN+1];
  int row_mm [2][MAX_LEN+1];
  int row_al [2][MAX_LEN+1];
  int len1, len2;
  bit full_band;
  int band_k;

  pair_result_t pending_scores[$];
  pair_result_t got_r;
  int errors;
  int quiet;
  int items_sent;
  bit calm;
  bit hold_req;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  function automatic int bump(int c);
    return c >= 4095 ? 4095 : c + 1;
  endfunction

  function automatic longint clamp_score(longint v);
    longint hi;
    hi = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic bit in_band(int i, int j);
    return full_band || (i - j >= -band_k && i - j <= band_k);
  endfunction

  function automatic void set_border(int row, int j, int len);
    row_score[row][j] = 0;
    row_move[row][j] = MOVE_NONE;
    row_mm[row][j] = 0;
    row_al[row][j] = len > 4095 ? 4095 : len;
  endfunction

  function automatic void align_pair(output pair_result_t r);
    longint best_r, best_c, diag, hor, ver, best, q;
    int mm_r, al_r, mm_c, al_c, mm, al, cur, prv;
    bit same;
    logic [2:0] m;
    best_r = 0; best_c = 0;
    mm_r = 0; al_r = 0; mm_c = 0; al_c = 0;
    cur = 0;
    r = '0;
    full_band = cf_band == 0;
    band_k = full_band ? 0 : (len1 + len2) / (2 * cf_band);
    for (int j = 0; j <= len1; j++)
      if (full_band || j <= band_k) set_border(0, j, j);
    for (int i = 1; i <= len2; i++) begin
      prv = cur;
      cur = cur ^ 1;
      if (full_band || i <= band_k) set_border(cur, 0, i);
      for (int j = 1; j <= len1; j++) begin
        if (!in_band(i, j)) begin
          row_score[cur][j] = 0;
          continue;
        end
        same = read2[i-1] == read1[j-1];
        diag = row_score[prv][j-1] + (same ? longint'(cf_match) : longint'(cf_mismatch));
        hor = OFF_BAND_SCORE;
        ver = OFF_BAND_SCORE;
        if (in_band(i, j - 1)) begin
          m = row_move[cur][j-1];
          hor = row_score[cur][j-1] + (m[0] ? longint'(cf_gap_open) : 0)
                + (m[2] ? longint'(cf_gap_extend) : 0);
        end
        if (in_band(i - 1, j)) begin
          m = row_move[prv][j];
          ver = row_score[prv][j] + (m[0] ? longint'(cf_gap_open) : 0)
                + (m[1] ? longint'(cf_gap_extend) : 0);
        end
        best = diag > hor ? diag : hor;
        if (ver > best) best = ver;
        if (best == diag) begin
          row_move[cur][j] = MOVE_DIAG;
          row_mm[cur][j] = same ? row_mm[prv][j-1] : bump(row_mm[prv][j-1]);
          row_al[cur][j] = bump(row_al[prv][j-1]);
        end else if (best == hor) begin
          row_move[cur][j] = MOVE_HOR;
          row_mm[cur][j] = bump(row_mm[cur][j-1]);
          row_al[cur][j] = bump(row_al[cur][j-1]);
        end else begin
          row_move[cur][j] = MOVE_VER;
          row_mm[cur][j] = bump(row_mm[prv][j]);
          row_al[cur][j] = bump(row_al[prv][j]);
        end
        best = clamp_score(best);
        row_score[cur][j] = best;
        if (i == len2 && best >= best_r) begin
          best_r = best;
          mm_r = row_mm[cur][j];
          al_r = row_al[cur][j];
        end
        if (j == len1 && best >= best_c) begin
          best_c = best;
          mm_c = row_mm[cur][j];
          al_c = row_al[cur][j];
        end
      end
    end
    if (best_r > best_c) begin
      mm = mm_r;
      al = al_r;
    end else begin
      mm = mm_c;
      al = al_c;
    end
    if (al != 0) begin
      q = ((longint'(mm) <<< 16) + (al >> 1)) / al;
      r.distance = q[16:0];
      r.acc = longint'(r.distance) <= longint'(cf_threshold) + cf_tolerance;
    end
    r.mm = mm[11:0];
    r.al = al[11:0];
  endfunction

  function automatic bit take_base(logic sel, logic [7:0] b, logic last,
                                   output pair_result_t r);
    r = '0;
    if (!sel) begin
      if (len1 < MAX_LEN) begin
        read1[len1] = b;
        len1++;
      end
    end else if (len2 < MAX_LEN) begin
      read2[len2] = b;
      len2++;
    end
    if (!last) return 0;
    if (len1 == 0 || len2 == 0) r.empty = 1'b1;
    else align_pair(r);
    len1 = 0;
    len2 = 0;
    return 1;
  endfunction

  task automatic send_item(logic sel, logic [7:0] b, logic last, logic typed,
                           pair_result_t typed_r);
    pair_result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sel;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (take_base(sel, b, last, r)) pending_scores.push_back(typed ? typed_r : r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int mt, int mis, int go, int ge, int thr, int tol, int bd);
    logic [CFG_IW-1:0] idx [8];
    int vals [8];
    idx = '{REG_MATCH, REG_MISMATCH, REG_GAP_OPEN, REG_GAP_EXTEND,
            REG_THRESHOLD, REG_TOLERANCE, REG_BAND_DIVISOR, REG_SPARE};
    vals = '{mt, mis, go, ge, thr, tol, bd, $urandom};
    for (int n = 0; n < 8; n++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[n];
      cfg_data <= vals[n][CFG_DW-1:0];
      @(posedge clk);
      case (idx[n])
        REG_MATCH:        cf_match = vals[n][7:0];
        REG_MISMATCH:     cf_mismatch = vals[n][7:0];
        REG_GAP_OPEN:     cf_gap_open = vals[n][7:0];
        REG_GAP_EXTEND:   cf_gap_extend = vals[n][7:0];
        REG_THRESHOLD:    cf_threshold = vals[n][16:0];
        REG_TOLERANCE:    cf_tolerance = vals[n][7:0];
        REG_BAND_DIVISOR: cf_band = vals[n][7:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 0;
    if (p < 90) return $urandom_range(1, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send_pair(int l1, int l2);
    int rem1, rem2, mode;
    bit narrow;
    logic [7:0] pool [4];
    logic sel;
    logic [7:0] b;
    rem1 = l1;
    rem2 = l2;
    mode = $urandom_range(0, 2);
    narrow = $urandom_range(0, 3) != 0;
    for (int n = 0; n < 4; n++) pool[n] = $urandom;
    while (rem1 + rem2 > 0) begin
      if (mode == 0) sel = rem1 == 0;
      else if (mode == 1) sel = rem2 != 0;
      else sel = rem1 == 0 || (rem2 != 0 && $urandom_range(0, 1) == 1);
      if (sel) rem2--;
      else rem1--;
      b = narrow ? pool[$urandom_range(0, 3)] : 8'($urandom);
      send_item(sel, b, rem1 + rem2 == 0, 1'b0, NO_R);
    end
  endtask

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        $error("result item with no pair outstanding");
        errors++;
      end else begin
        got_r = pending_scores.pop_front();
        check_field("distance", got_r.distance, m_axis_tdata[16:0]);
        check_field("mismatch_count", got_r.mm, m_axis_tdata[28:17]);
        check_field("align_length", got_r.al, m_axis_tdata[40:29]);
        check_field("accepted", got_r.acc, m_axis_tdata[41]);
        check_field("empty_pair", got_r.empty, m_axis_tuser);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL banded_alignment_distance");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t rows [20];
    rows = '{
      '{1'b1, 8'h00, 1'b1, 1'b1, EMPTY_R},
      '{1'b0, 8'hFF, 1'b1, 1'b1, EMPTY_R},
      '{1'b0, 8'h41, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h41, 1'b1, 1'b1, IDENT_R},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'hFF, 1'b1, 1'b0, NO_R},
      '{1'b1, 8'h12, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h34, 1'b0, 1'b0, NO_R},
      '{1'b0, 8'h12, 1'b0, 1'b0, NO_R},
      '{1'b0, 8'h34, 1'b1, 1'b0, NO_R},
      '{1'b0, 8'h41, 1'b0, 1'b0, NO_R},
      '{1'b0, 8'h43, 1'b0, 1'b0, NO_R},
      '{1'b0, 8'h47, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h41, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h47, 1'b1, 1'b0, NO_R},
      '{1'b0, 8'h80, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h7F, 1'b0, 1'b0, NO_R},
      '{1'b0, 8'h01, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'h80, 1'b0, 1'b0, NO_R},
      '{1'b1, 8'hAA, 1'b1, 1'b0, NO_R}
    };
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MATCH;
    cfg_data = '0;
    errors = 0;
    quiet = 0;
    items_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    cf_match = 1;
    cf_mismatch = -1;
    cf_gap_open = -2;
    cf_gap_extend = -1;
    cf_threshold = 6554;
    cf_tolerance = 1;
    cf_band = 0;
    len1 = 0;
    len2 = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[n]) send_item(rows[n].sel, rows[n].b, rows[n].last, rows[n].typed, rows[n].r);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        1: set_config(127, -128, -128, -128, 0, 0, 1);
        2: set_config(-128, 127, 127, 127, 65536, 255, 255);
        3: set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 65536),
                      $urandom_range(0, 255), $urandom_range(1, 4));
        4: set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 65536),
                      $urandom_range(0, 255), 0);
        5: set_config(2, -3, -5, -1, 6554, 1, 2);
        default: ;
      endcase
      if (p == 2) hold_req = 1'b1;
      if (p == 5) calm = 1'b1;
      if (p == 1) begin
        // first read overruns its store; the extra bases are dropped
        for (int n = 0; n < 1030; n++) send_item(1'b0, 8'($urandom), 1'b0, 1'b0, NO_R);
        send_item(1'b1, 8'($urandom), 1'b1, 1'b0, NO_R);
        items_sent -= 1031;
      end
      while (items_sent < PHASE_ITEMS * (p + 1) + 20) begin
        int l1, l2;
        l1 = pick_len();
        l2 = pick_len();
        if (l1 + l2 == 0) l1 = 1;
        send_pair(l1, l2);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("PASS banded_alignment_distance");
    else
      $display("FAIL banded_alignment_distance");
    $finish;
  end

endmodule

>>> files.f
src/bad_pkg.sv
src/bad_jobq.sv
src/bad_div.sv
src/bad_front.sv
src/bad_core.sv
src/banded_alignment_distance.sv
sim/tb.sv
